FILE: rtl/lkoc_pkg.sv
// Package for the keyed LRU object cache: sizes, operation and partition codes,
// result selects, controller/datapath command and status structs.
// No dependencies.
package lkoc_pkg;

  localparam int unsigned ENTRIES   = 32;
  localparam int unsigned NPART     = 3;
  localparam int unsigned MIN_CAP   = 2;
  localparam int unsigned RESET_CAP = 32;

  localparam int unsigned IDX_W  = $clog2(ENTRIES);
  localparam int unsigned RANK_W = $clog2(ENTRIES);
  localparam int unsigned CNT_W  = $clog2(ENTRIES + 1);
  localparam int unsigned PART_W = $clog2(NPART);
  localparam int unsigned ADDR_W = $clog2(NPART * ENTRIES);
  localparam int unsigned DEPTH  = NPART * ENTRIES;

  localparam int unsigned KEY_W = 64;
  localparam int unsigned HDL_W = 32;
  localparam int unsigned CAP_W = 6;

  localparam logic [1:0] KIND_SET = 2'd0;
  localparam logic [1:0] KIND_GET = 2'd1;
  localparam logic [1:0] KIND_DEL = 2'd2;

  localparam logic [1:0] PART_MESSAGE = 2'd0;
  localparam logic [1:0] PART_CHANNEL = 2'd1;
  localparam logic [1:0] PART_GUILD   = 2'd2;

  typedef enum logic [2:0] {
    RES_ZERO,
    RES_SET,
    RES_GET,
    RES_DEL,
    RES_EVICT
  } res_e;

  typedef struct packed {
    logic latch;
    logic search;
    logic rd_hit;
    logic find_old;
    logic emit;
    res_e sel;
    logic last;
    logic touch;
    logic write_hit;
    logic remove_hit;
    logic remove_old;
    logic insert;
  } lkoc_cmd_t;

  typedef struct packed {
    logic item_ok;
    logic is_set;
    logic is_get;
    logic is_del;
    logic hit;
    logic over;
    logic last_evict;
    logic out_free;
  } lkoc_sts_t;

  function automatic logic [CNT_W-1:0] cap_clamp(input logic [CAP_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (32'(v) < MIN_CAP) r = CNT_W'(MIN_CAP);
    else if (32'(v) > ENTRIES) r = CNT_W'(ENTRIES);
    else r = CNT_W'(v);
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] mem_addr(input logic [PART_W-1:0] p,
                                                  input logic [IDX_W-1:0] i);
    return ADDR_W'(p) * ADDR_W'(ENTRIES) + ADDR_W'(i);
  endfunction

endpackage

FILE: rtl/lkoc_if.sv
// Channel interfaces of the keyed LRU object cache: request, result, config write.
// Depends on nothing.
interface lkoc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [1:0]  partition;
  logic [63:0] lookup_id;
  logic [31:0] object_handle;
  modport source (output valid, kind, partition, lookup_id, object_handle, input ready);
  modport sink (input valid, kind, partition, lookup_id, object_handle, output ready);
endinterface

interface lkoc_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [31:0] handle_out;
  logic        is_eviction;
  logic [63:0] evicted_id;
  logic        last;
  modport source (output valid, found, handle_out, is_eviction, evicted_id, last,
                  input ready);
  modport sink (input valid, found, handle_out, is_eviction, evicted_id, last,
                output ready);
endinterface

interface lkoc_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [5:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/lkoc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lkoc_ram #(
  parameter int unsigned DEPTH = 96,
  parameter int unsigned WIDTH = 96
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
  end

  always_ff @(posedge clk_i) begin
    if (re_i) rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/lkoc_datapath.sv
// Datapath: key cells with parallel compare, valid/rank/count state, capacity
// registers, key+handle RAM and the result register. Uses lkoc_pkg, lkoc_ram.
module lkoc_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lkoc_pkg::lkoc_cmd_t cmd_i,
  output lkoc_pkg::lkoc_sts_t sts_o,
  input  logic [1:0]        kind_i,
  input  logic [1:0]        partition_i,
  input  logic [63:0]       lookup_id_i,
  input  logic [31:0]       object_handle_i,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [5:0]        cfg_data_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic              found_o,
  output logic [31:0]       handle_out_o,
  output logic              is_eviction_o,
  output logic [63:0]       evicted_id_o,
  output logic              last_o
);
  import lkoc_pkg::*;

  logic [1:0]        kind_q, part_q;
  logic [KEY_W-1:0]  id_q;
  logic [HDL_W-1:0]  obj_q;

  logic [KEY_W-1:0]   key_q  [NPART][ENTRIES];
  logic [ENTRIES-1:0] valid_q [NPART];
  logic [RANK_W-1:0]  rank_q [NPART][ENTRIES];
  logic [CNT_W-1:0]   cnt_q  [NPART];
  logic [CNT_W-1:0]   cap_q  [NPART];

  logic              hit_q;
  logic [IDX_W-1:0]  hit_idx_q, old_idx_q;
  logic [RANK_W-1:0] hit_rank_q;

  logic              part_ok, kind_ok;
  logic [PART_W-1:0] pi;
  logic [ENTRIES-1:0] hit_vec, old_vec;
  logic [IDX_W-1:0]  hit_idx, old_idx, free_idx;
  logic [CNT_W-1:0]  cnt, lim;
  logic              out_free;

  logic                    mem_we, mem_re;
  logic [ADDR_W-1:0]       mem_waddr, mem_raddr;
  logic [KEY_W+HDL_W-1:0]  mem_rdata;

  logic              out_valid_q, found_q, evict_q, last_q;
  logic [HDL_W-1:0]  hdl_out_q;
  logic [KEY_W-1:0]  id_out_q;

  assign part_ok = (part_q == PART_MESSAGE) || (part_q == PART_CHANNEL) ||
                   (part_q == PART_GUILD);
  assign kind_ok = (kind_q == KIND_SET) || (kind_q == KIND_GET) || (kind_q == KIND_DEL);
  assign pi      = part_ok ? PART_W'(part_q) : '0;
  assign cnt     = cnt_q[pi];
  assign lim     = hit_q ? cap_q[pi] : cap_q[pi] - CNT_W'(1);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    hit_idx  = '0;
    old_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i] = valid_q[pi][i] && (key_q[pi][i] == id_q);
      old_vec[i] = valid_q[pi][i] && (CNT_W'(rank_q[pi][i]) == cnt - CNT_W'(1));
      if (hit_vec[i]) hit_idx = IDX_W'(i);
      if (old_vec[i]) old_idx = IDX_W'(i);
    end
    // lowest free slot wins
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_q[pi][i]) free_idx = IDX_W'(i);
    end
  end

  always_comb begin
    sts_o.item_ok    = kind_ok && part_ok;
    sts_o.is_set     = (kind_q == KIND_SET);
    sts_o.is_get     = (kind_q == KIND_GET);
    sts_o.is_del     = (kind_q == KIND_DEL);
    sts_o.hit        = hit_q;
    sts_o.over       = cnt > lim;
    sts_o.last_evict = (cnt - CNT_W'(1)) <= lim;
    sts_o.out_free   = out_free;
  end

  // item and search registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      kind_q <= kind_i;
      part_q <= partition_i;
      id_q   <= lookup_id_i;
      obj_q  <= object_handle_i;
    end
    if (cmd_i.search) begin
      hit_q      <= |hit_vec;
      hit_idx_q  <= hit_idx;
      hit_rank_q <= rank_q[pi][hit_idx];
    end
    if (cmd_i.find_old) old_idx_q <= old_idx;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.insert) key_q[pi][free_idx] <= id_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [RANK_W-1:0] r;
    logic [IDX_W-1:0]  ri;
    if (!rst_ni) begin
      for (int p = 0; p < NPART; p++) begin
        valid_q[p] <= '0;
        cnt_q[p]   <= '0;
        for (int i = 0; i < ENTRIES; i++) rank_q[p][i] <= '0;
      end
    end else begin
      r  = cmd_i.remove_old ? RANK_W'(cnt - CNT_W'(1)) : hit_rank_q;
      ri = cmd_i.remove_old ? old_idx_q : hit_idx_q;
      if (cmd_i.touch) begin
        for (int i = 0; i < ENTRIES; i++)
          if (valid_q[pi][i] && rank_q[pi][i] < hit_rank_q)
            rank_q[pi][i] <= rank_q[pi][i] + RANK_W'(1);
        rank_q[pi][hit_idx_q] <= '0;
      end else if (cmd_i.remove_hit || cmd_i.remove_old) begin
        for (int i = 0; i < ENTRIES; i++)
          if (valid_q[pi][i] && rank_q[pi][i] > r)
            rank_q[pi][i] <= rank_q[pi][i] - RANK_W'(1);
        valid_q[pi][ri] <= 1'b0;
        rank_q[pi][ri]  <= '0;
        cnt_q[pi]       <= cnt - CNT_W'(1);
      end else if (cmd_i.insert) begin
        for (int i = 0; i < ENTRIES; i++)
          if (valid_q[pi][i]) rank_q[pi][i] <= rank_q[pi][i] + RANK_W'(1);
        valid_q[pi][free_idx] <= 1'b1;
        rank_q[pi][free_idx]  <= '0;
        cnt_q[pi]             <= cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NPART; p++) cap_q[p] <= cap_clamp(CAP_W'(RESET_CAP));
    end else if (cfg_we_i && (32'(cfg_index_i) < NPART)) begin
      cap_q[PART_W'(cfg_index_i)] <= cap_clamp(cfg_data_i);
    end
  end

  assign mem_we    = cmd_i.write_hit || cmd_i.insert;
  assign mem_waddr = mem_addr(pi, cmd_i.insert ? free_idx : hit_idx_q);
  assign mem_re    = cmd_i.rd_hit || cmd_i.find_old;
  assign mem_raddr = mem_addr(pi, cmd_i.find_old ? old_idx : hit_idx_q);

  lkoc_ram #(
    .DEPTH(DEPTH),
    .WIDTH(KEY_W + HDL_W)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i({id_q, obj_q}),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.emit) out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      last_q    <= cmd_i.last;
      found_q   <= 1'b0;
      evict_q   <= 1'b0;
      hdl_out_q <= '0;
      id_out_q  <= '0;
      case (cmd_i.sel)
        RES_SET: found_q <= hit_q;
        RES_GET: begin
          found_q   <= 1'b1;
          hdl_out_q <= mem_rdata[HDL_W-1:0];
        end
        RES_DEL: begin
          found_q   <= 1'b1;
          hdl_out_q <= mem_rdata[HDL_W-1:0];
          id_out_q  <= mem_rdata[KEY_W+HDL_W-1:HDL_W];
        end
        RES_EVICT: begin
          evict_q   <= 1'b1;
          hdl_out_q <= mem_rdata[HDL_W-1:0];
          id_out_q  <= mem_rdata[KEY_W+HDL_W-1:HDL_W];
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = found_q;
  assign handle_out_o  = hdl_out_q;
  assign is_eviction_o = evict_q;
  assign evicted_id_o  = id_out_q;
  assign last_o        = last_q;

`ifndef SYNTHESIS
  a_cnt0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q[0]) == $countones(valid_q[0])) else $error("count 0 off");
  a_cnt1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q[1]) == $countones(valid_q[1])) else $error("count 1 off");
  a_cnt2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q[2]) == $countones(valid_q[2])) else $error("count 2 off");
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || out_ready_i)) else $error("word overwritten");
`endif

endmodule

FILE: rtl/lkoc_ctrl.sv
// Controller state machine: sequences search, read, emit, eviction and insert.
// Uses lkoc_pkg.
module lkoc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lkoc_pkg::lkoc_sts_t sts_i,
  output lkoc_pkg::lkoc_cmd_t cmd_o
);
  import lkoc_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SEARCH  = 4'd1;
  localparam logic [3:0] S_DECIDE  = 4'd2;
  localparam logic [3:0] S_RDWAIT  = 4'd3;
  localparam logic [3:0] S_HITEMIT = 4'd4;
  localparam logic [3:0] S_SETEMIT = 4'd5;
  localparam logic [3:0] S_EVFIND  = 4'd6;
  localparam logic [3:0] S_EVEMIT  = 4'd7;
  localparam logic [3:0] S_INSERT  = 4'd8;
  localparam logic [3:0] S_ZERO    = 4'd9;

  logic [3:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.sel = RES_ZERO;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d = S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd_o.search = 1'b1;
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (!sts_i.item_ok) state_d = S_ZERO;
        else if (sts_i.is_set) state_d = S_SETEMIT;
        else if (sts_i.hit) begin
          cmd_o.rd_hit = 1'b1;
          state_d = S_RDWAIT;
        end else state_d = S_ZERO;
      end
      S_RDWAIT: state_d = S_HITEMIT;
      S_HITEMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit       = 1'b1;
          cmd_o.sel        = sts_i.is_get ? RES_GET : RES_DEL;
          cmd_o.last       = 1'b1;
          cmd_o.touch      = sts_i.is_get;
          cmd_o.remove_hit = sts_i.is_del;
          state_d = S_IDLE;
        end
      end
      S_SETEMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.sel       = RES_SET;
          cmd_o.last      = !sts_i.over;
          cmd_o.write_hit = sts_i.hit;
          cmd_o.touch     = sts_i.hit;
          if (sts_i.over) state_d = S_EVFIND;
          else state_d = sts_i.hit ? S_IDLE : S_INSERT;
        end
      end
      S_EVFIND: begin
        cmd_o.find_old = 1'b1;
        state_d = S_EVEMIT;
      end
      S_EVEMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit       = 1'b1;
          cmd_o.sel        = RES_EVICT;
          cmd_o.last       = sts_i.last_evict;
          cmd_o.remove_old = 1'b1;
          if (!sts_i.last_evict) state_d = S_EVFIND;
          else state_d = sts_i.hit ? S_IDLE : S_INSERT;
        end
      end
      S_INSERT: begin
        cmd_o.insert = 1'b1;
        state_d = S_IDLE;
      end
      S_ZERO: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = RES_ZERO;
          cmd_o.last = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

endmodule

FILE: rtl/lru_keyed_object_cache_unit.sv
// Keyed LRU object cache with three partitions (message, channel, guild).
// Request channel in_i, result channel out_o, capacity write channel cfg_i.
// A request is taken only while the unit is idle; each request yields one or
// more result words, the final one flagged by last.
// A set returns one word, then one eviction word per entry dropped (oldest
// first); get and delete return one word; bad kind or partition returns zeros.
// The controller runs one request at a time: search, a registered RAM read
// (get/delete hits and each eviction), then the result register; a set with a
// new key inserts it after its result and eviction words.
// Capacity writes (index 0..2) take effect at once, clamped to 2..32; other
// indexes are dropped. cfg_i is always ready.
// Reset empties all partitions and sets each capacity to 32; no RAM clear runs.
// When out_o stalls, the result word holds in its register and the controller
// waits before producing the next word.
// Uses lkoc_pkg, lkoc_if, lkoc_ctrl, lkoc_datapath.
module lru_keyed_object_cache_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  lkoc_in_if.sink   in_i,
  lkoc_out_if.source out_o,
  lkoc_cfg_if.sink  cfg_i
);
  import lkoc_pkg::*;

  lkoc_cmd_t cmd;
  lkoc_sts_t sts;
  logic      in_ready;

  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;

  lkoc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_i.valid),
    .in_ready_o(in_ready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  lkoc_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .kind_i         (in_i.kind),
    .partition_i    (in_i.partition),
    .lookup_id_i    (in_i.lookup_id),
    .object_handle_i(in_i.object_handle),
    .cfg_we_i       (cfg_i.valid),
    .cfg_index_i    (cfg_i.index),
    .cfg_data_i     (cfg_i.data),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .found_o        (out_o.found),
    .handle_out_o   (out_o.handle_out),
    .is_eviction_o  (out_o.is_eviction),
    .evicted_id_o   (out_o.evicted_id),
    .last_o         (out_o.last)
  );

endmodule

FILE: verif/lru_keyed_object_cache_unit_tb.sv
// Testbench for the keyed LRU object cache: drives requests and capacity writes,
// predicts every result word with a local LRU store, and checks words in order.
// Depends on lkoc_pkg, lkoc_if and lru_keyed_object_cache_unit.
`timescale 1ns / 1ps
module lru_keyed_object_cache_unit_tb;
  import lkoc_pkg::*;

  typedef struct packed {
    logic        found;
    logic [31:0] handle_out;
    logic        is_eviction;
    logic [63:0] evicted_id;
    logic        last;
  } word_t;

  localparam int IDLE_NONE = 0;
  localparam int IDLE_SEND = 1;
  localparam int IDLE_RECV = 2;
  localparam int IDLE_BOTH = 3;
  localparam int WATCH_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  lkoc_in_if  in_if ();
  lkoc_out_if out_if ();
  lkoc_cfg_if cfg_if ();

  lru_keyed_object_cache_unit dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .out_o (out_if.source),
    .cfg_i (cfg_if.sink)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // model state
  logic [63:0] mdl_key [DEPTH];
  logic [31:0] mdl_hdl [DEPTH];
  logic        mdl_vld [DEPTH];
  int          mdl_rank [DEPTH];
  int          mdl_cnt [NPART];
  int          mdl_cap [NPART];

  word_t expected_words[$];
  int    errors = 0;
  int    idle_mode = IDLE_NONE;
  int    quiet_cycles = 0;
  int    key_pool = 8;

  function automatic int clamp_capacity(logic [5:0] v);
    if (v < MIN_CAP) return MIN_CAP;
    if (v > ENTRIES) return ENTRIES;
    return int'(v);
  endfunction

  function automatic void push_word(logic f, logic [31:0] h, logic e, logic [63:0] id);
    word_t w;
    w.found = f; w.handle_out = h; w.is_eviction = e; w.evicted_id = id; w.last = 1'b0;
    expected_words.push_back(w);
  endfunction

  function automatic int lookup(int p, logic [63:0] k);
    for (int i = p * ENTRIES; i < (p + 1) * ENTRIES; i++)
      if (mdl_vld[i] && mdl_key[i] == k) return i;
    return -1;
  endfunction

  function automatic void promote(int p, int idx);
    int r;
    r = mdl_rank[idx];
    for (int i = p * ENTRIES; i < (p + 1) * ENTRIES; i++)
      if (mdl_vld[i] && mdl_rank[i] < r) mdl_rank[i]++;
    mdl_rank[idx] = 0;
  endfunction

  function automatic void drop_entry(int p, int idx);
    int r;
    r = mdl_rank[idx];
    for (int i = p * ENTRIES; i < (p + 1) * ENTRIES; i++)
      if (mdl_vld[i] && mdl_rank[i] > r) mdl_rank[i]--;
    mdl_vld[idx] = 1'b0;
    mdl_rank[idx] = 0;
    if (mdl_cnt[p] > 0) mdl_cnt[p]--;
  endfunction

  function automatic void evict_down(int p, int limit);
    int o;
    while (mdl_cnt[p] > limit) begin
      o = -1;
      for (int i = p * ENTRIES; i < (p + 1) * ENTRIES; i++)
        if (mdl_vld[i] && mdl_rank[i] == mdl_cnt[p] - 1) o = i;
      if (o < 0) break;
      push_word(1'b0, mdl_hdl[o], 1'b1, mdl_key[o]);
      drop_entry(p, o);
    end
  endfunction

  function automatic void predict_request(logic [1:0] kind, logic [1:0] part,
                                          logic [63:0] k, logic [31:0] h);
    int p;
    int idx;
    int slot;
    p = int'(part);
    if (kind > KIND_DEL || part > PART_GUILD) begin
      push_word(1'b0, '0, 1'b0, '0);
    end else begin
      idx = lookup(p, k);
      if (kind == KIND_SET) begin
        if (idx >= 0) begin
          mdl_hdl[idx] = h;
          promote(p, idx);
          push_word(1'b1, '0, 1'b0, '0);
          evict_down(p, mdl_cap[p]);
        end else begin
          push_word(1'b0, '0, 1'b0, '0);
          evict_down(p, mdl_cap[p] - 1);
          slot = -1;
          for (int i = p * ENTRIES; i < (p + 1) * ENTRIES; i++)
            if (slot < 0 && !mdl_vld[i]) slot = i;
          if (slot >= 0) begin
            for (int i = p * ENTRIES; i < (p + 1) * ENTRIES; i++)
              if (mdl_vld[i]) mdl_rank[i]++;
            mdl_vld[slot] = 1'b1; mdl_key[slot] = k; mdl_hdl[slot] = h;
            mdl_rank[slot] = 0; mdl_cnt[p]++;
          end
        end
      end else if (kind == KIND_GET) begin
        if (idx >= 0) begin
          promote(p, idx);
          push_word(1'b1, mdl_hdl[idx], 1'b0, '0);
        end else push_word(1'b0, '0, 1'b0, '0);
      end else begin
        if (idx >= 0) begin
          push_word(1'b1, mdl_hdl[idx], 1'b0, mdl_key[idx]);
          drop_entry(p, idx);
        end else push_word(1'b0, '0, 1'b0, '0);
      end
    end
    expected_words[$].last = 1'b1;
  endfunction

  function automatic bit pick(int pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  task automatic send_request(logic [1:0] kind, logic [1:0] part,
                              logic [63:0] k, logic [31:0] h);
    while ((idle_mode == IDLE_SEND && pick(54)) || (idle_mode == IDLE_BOTH && pick(8)))
      @(posedge clk_i);
    in_if.valid <= 1'b1;
    in_if.kind <= kind;
    in_if.partition <= part;
    in_if.lookup_id <= k;
    in_if.object_handle <= h;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predict_request(kind, part, k, h);
    in_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [1:0] idx, logic [5:0] v);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= v;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    if (idx < NPART) mdl_cap[idx] = clamp_capacity(v);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // keys drawn from a small pool so sets, gets and deletes hit often
  function automatic logic [63:0] pool_key(int p);
    logic [63:0] k;
    k = {$urandom, $urandom};
    if (pick(85)) k = {k[63:56], 48'h0, 8'($urandom_range(key_pool - 1, 0))};
    return k;
  endfunction

  task automatic test_directed();
    send_request(KIND_GET, PART_MESSAGE, '0, '0);
    send_request(KIND_SET, PART_MESSAGE, '0, '1);
    send_request(KIND_SET, PART_MESSAGE, '1, '0);
    send_request(KIND_SET, PART_MESSAGE, '0, 32'h5a5a_a5a5);
    send_request(KIND_GET, PART_MESSAGE, '0, '0);
    send_request(KIND_GET, PART_MESSAGE, '1, '1);
    send_request(KIND_DEL, PART_MESSAGE, '1, '0);
    send_request(KIND_DEL, PART_MESSAGE, '1, '0);
    send_request(KIND_SET, PART_CHANNEL, 64'h8000_0000_0000_0001, 32'h8000_0001);
    send_request(KIND_SET, PART_GUILD, 64'h7fff_ffff_ffff_fffe, 32'h7fff_fffe);
    send_request(KIND_GET, PART_CHANNEL, 64'h8000_0000_0000_0001, '0);
    send_request(2'd3, PART_MESSAGE, '1, '1);
    send_request(KIND_GET, 2'd3, '0, '0);
    send_request(2'd3, 2'd3, '1, '1);
    drain();
    // smallest capacity: third new key evicts the oldest
    write_capacity(PART_GUILD, 6'd0);
    write_capacity(PART_CHANNEL, 6'd1);
    write_capacity(2'd3, 6'd5);
    send_request(KIND_SET, PART_GUILD, 64'd1, 32'd11);
    send_request(KIND_SET, PART_GUILD, 64'd2, 32'd22);
    send_request(KIND_GET, PART_GUILD, 64'd1, '0);
    send_request(KIND_SET, PART_GUILD, 64'd3, 32'd33);
    send_request(KIND_SET, PART_GUILD, 64'd1, 32'd44);
    drain();
  endtask

  task automatic test_random(int n, int mode);
    logic [1:0] kind;
    logic [1:0] part;
    idle_mode = mode;
    for (int i = 0; i < n; i++) begin
      kind = pick(5) ? 2'd3 : 2'($urandom_range(2, 0));
      if (kind == KIND_SET && pick(30)) kind = KIND_SET;
      part = pick(4) ? 2'd3 : 2'($urandom_range(2, 0));
      send_request(kind, part, pool_key(int'(part)), $urandom);
    end
    drain();
  endtask

  task automatic test_capacity_shrink();
    // fill the message partition, then shrink so one set evicts many
    write_capacity(PART_MESSAGE, 6'd63);
    key_pool = 40;
    for (int i = 0; i < 34; i++) send_request(KIND_SET, PART_MESSAGE, 64'(i), $urandom);
    drain();
    write_capacity(PART_MESSAGE, 6'd2);
    send_request(KIND_GET, PART_MESSAGE, 64'd5, '0);
    send_request(KIND_SET, PART_MESSAGE, 64'd33, 32'hffff_ffff);
    drain();
    key_pool = 8;
  endtask

  // result checking and receiver stalls
  always @(posedge clk_i) begin
    word_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected result word");
          errors++;
        end else begin
          want = expected_words.pop_front();
          if (out_if.found !== want.found) begin
            $error("found exp %0h got %0h", want.found, out_if.found); errors++;
          end
          if (out_if.handle_out !== want.handle_out) begin
            $error("handle_out exp %0h got %0h", want.handle_out, out_if.handle_out);
            errors++;
          end
          if (out_if.is_eviction !== want.is_eviction) begin
            $error("is_eviction exp %0h got %0h", want.is_eviction, out_if.is_eviction);
            errors++;
          end
          if (out_if.evicted_id !== want.evicted_id) begin
            $error("evicted_id exp %0h got %0h", want.evicted_id, out_if.evicted_id);
            errors++;
          end
          if (out_if.last !== want.last) begin
            $error("last exp %0h got %0h", want.last, out_if.last); errors++;
          end
        end
      end
      out_if.ready <= !((idle_mode == IDLE_RECV && pick(54)) ||
                        (idle_mode == IDLE_BOTH && pick(8)));
    end
  end

  // watchdog: count cycles with no word moving on any channel
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCH_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.kind = '0;
    in_if.partition = '0;
    in_if.lookup_id = '0;
    in_if.object_handle = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      mdl_vld[i] = 1'b0; mdl_rank[i] = 0; mdl_key[i] = '0; mdl_hdl[i] = '0;
    end
    for (int p = 0; p < NPART; p++) begin
      mdl_cnt[p] = 0; mdl_cap[p] = RESET_CAP;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_capacity_shrink();
    write_capacity(PART_MESSAGE, 6'd4);
    write_capacity(PART_CHANNEL, 6'd32);
    write_capacity(PART_GUILD, 6'd3);
    test_random(110, IDLE_NONE);
    write_capacity(PART_MESSAGE, 6'd2);
    write_capacity(PART_CHANNEL, 6'd6);
    test_random(110, IDLE_SEND);
    write_capacity(PART_GUILD, 6'd63);
    write_capacity(PART_CHANNEL, 6'd3);
    test_random(110, IDLE_RECV);
    write_capacity(PART_MESSAGE, 6'd5);
    write_capacity(PART_GUILD, 6'd2);
    test_random(110, IDLE_BOTH);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/lkoc_pkg.sv
rtl/lkoc_if.sv
rtl/lkoc_ram.sv
rtl/lkoc_datapath.sv
rtl/lkoc_ctrl.sv
rtl/lru_keyed_object_cache_unit.sv
verif/lru_keyed_object_cache_unit_tb.sv
